FILE: hw/rtl/sbfsm_pkg.sv
// ----------------------------------------------------------------------------
// sbfsm_pkg
// shared codes for the size-binned free-space map
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbfsm_pkg;

  localparam int NumClasses = 256;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_POP_LB = 2'd1,
    ACT_POP_EX = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/size_binned_free_space_map.sv
// ----------------------------------------------------------------------------
// size_binned_free_space_map
// segregated free list of addresses, one block chain per size class
// ----------------------------------------------------------------------------
// One item at a time. Class heads and block headers (link, fill) share one
// metadata memory; addresses live in an entry memory, both with registered
// reads. An insert walks the class chain block by block; a lower-bound pop
// skips empty classes one at a time; an exact pop compares entries one by
// one, shifts the later entries down and walks on block by block. The
// result register lets a new item in while the previous result waits. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module size_binned_free_space_map #(
  parameter int ENTRIES_PER_BLOCK = 8,
  parameter int NUM_BLOCKS        = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  size_class,
  input  wire logic [31:0] address,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      result_address,
  output logic [1:0]       status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data
);
  import sbfsm_pkg::*;

  localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LW  = BW + 1;
  localparam int FW  = $clog2(ENTRIES_PER_BLOCK + 1);
  localparam int MW  = LW + FW;
  localparam int MAW = $clog2(NUM_BLOCKS + NumClasses);
  localparam int EAW = $clog2(NUM_BLOCKS * ENTRIES_PER_BLOCK);
  localparam int CW  = $clog2(NUM_BLOCKS + 1);
  localparam logic [LW-1:0] LinkNull = {1'b1, {BW{1'b0}}};
  localparam logic [FW-1:0] FillMax  = FW'(ENTRIES_PER_BLOCK);

  typedef enum logic [19:0] {
    S_IDLE   = 20'h00001,
    S_DISP   = 20'h00002,
    S_IHEAD  = 20'h00004,
    S_IBLK   = 20'h00008,
    S_IALLOC = 20'h00010,
    S_ISPARE = 20'h00020,
    S_INEW   = 20'h00040,
    S_ILINK  = 20'h00080,
    S_SCAN   = 20'h00100,
    S_LHEAD  = 20'h00200,
    S_LBLK   = 20'h00400,
    S_LENT   = 20'h00800,
    S_XHEAD  = 20'h01000,
    S_XBLK   = 20'h02000,
    S_XCMP   = 20'h04000,
    S_XSH    = 20'h08000,
    S_XSW    = 20'h10000,
    S_XFIN   = 20'h20000,
    S_REC    = 20'h40000,
    S_FIN    = 20'h80000
  } state_t;

  state_t state;

  logic [MW-1:0]  meta_mem [NUM_BLOCKS + NumClasses];
  logic [31:0]    entry_mem [NUM_BLOCKS * ENTRIES_PER_BLOCK];
  logic [MW-1:0]  meta_q;
  logic [31:0]    entry_q;
  logic           meta_we, meta_re, entry_we, entry_re;
  logic [MAW-1:0] meta_waddr, meta_raddr;
  logic [MW-1:0]  meta_wdata;
  logic [EAW-1:0] entry_waddr, entry_raddr;
  logic [31:0]    entry_wdata;

  logic [8:0]           classes_in_use;
  logic [NumClasses-1:0] class_ne;
  logic [LW-1:0]        spare_head;
  logic [CW-1:0]        fresh_count;
  action_t              act;
  logic [7:0]           cls;
  logic [31:0]          addr;
  logic [31:0]          res;
  status_t              st;
  logic [8:0]           cur;
  logic [BW-1:0]        blk;
  logic [LW-1:0]        link_b;
  logic [FW-1:0]        fill_b;
  logic [LW-1:0]        prev;
  logic [FW-1:0]        prev_fill;
  logic [FW-1:0]        idx;

  logic [8:0]    lim;
  logic          active;
  logic [LW-1:0] mq_link;
  logic [FW-1:0] mq_fill;
  logic [FW-1:0] lb_fill;
  logic          idx_more;
  logic          out_free;
  logic [MAW-1:0] head_addr, cur_addr;
  logic [EAW-1:0] blk_base;

  assign lim       = (classes_in_use > 9'(NumClasses)) ? 9'(NumClasses) : classes_in_use;
  assign active    = {1'b0, cls} < lim;
  assign mq_link   = meta_q[MW-1:FW];
  assign mq_fill   = meta_q[FW-1:0];
  assign lb_fill   = (mq_fill == '0) ? FW'(1) : mq_fill;
  assign idx_more  = ({1'b0, idx} + (FW+1)'(1)) < {1'b0, fill_b};
  assign out_free  = !result_valid || !result_stall;
  assign head_addr = MAW'(NUM_BLOCKS) + MAW'(cls);
  assign cur_addr  = MAW'(NUM_BLOCKS) + MAW'(cur[7:0]);
  assign blk_base  = EAW'(blk) * EAW'(ENTRIES_PER_BLOCK);

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  // memory port control
  always_comb begin
    meta_we     = 1'b0;
    meta_re     = 1'b0;
    entry_we    = 1'b0;
    entry_re    = 1'b0;
    meta_waddr  = MAW'(blk);
    meta_raddr  = head_addr;
    meta_wdata  = '0;
    entry_waddr = blk_base + EAW'(idx);
    entry_raddr = blk_base;
    entry_wdata = addr;
    case (state)
      S_DISP: begin
        if (((act == ACT_INSERT) || (act == ACT_POP_EX)) && active && class_ne[cls]) begin
          meta_re = 1'b1;
        end
      end
      S_IHEAD, S_LHEAD, S_XHEAD: begin
        meta_re    = 1'b1;
        meta_raddr = MAW'(mq_link[BW-1:0]);
      end
      S_IBLK: begin
        if (mq_fill < FillMax) begin
          entry_we    = 1'b1;
          entry_waddr = blk_base + EAW'(mq_fill);
          meta_we     = 1'b1;
          meta_wdata  = {mq_link, mq_fill + FW'(1)};
        end else if (!mq_link[LW-1]) begin
          meta_re    = 1'b1;
          meta_raddr = MAW'(mq_link[BW-1:0]);
        end
      end
      S_IALLOC: begin
        if (!spare_head[LW-1]) begin
          meta_re    = 1'b1;
          meta_raddr = MAW'(spare_head[BW-1:0]);
        end
      end
      S_INEW: begin
        meta_we     = 1'b1;
        meta_wdata  = {LinkNull, FW'(1)};
        entry_we    = 1'b1;
        entry_waddr = blk_base;
      end
      S_ILINK: begin
        meta_we = 1'b1;
        if (!prev[LW-1]) begin
          meta_waddr = MAW'(prev[BW-1:0]);
          meta_wdata = {1'b0, blk, FillMax};
        end else begin
          meta_waddr = head_addr;
          meta_wdata = {1'b0, blk, FW'(0)};
        end
      end
      S_SCAN: begin
        meta_raddr = cur_addr;
        meta_re    = (cur < lim) && class_ne[cur[7:0]];
      end
      S_LBLK: begin
        entry_re    = 1'b1;
        entry_raddr = blk_base + EAW'(lb_fill - FW'(1));
      end
      S_LENT: begin
        meta_we = 1'b1;
        if (fill_b != FW'(1)) begin
          meta_wdata = {link_b, fill_b - FW'(1)};
        end else begin
          meta_waddr = cur_addr;
          meta_wdata = {link_b, FW'(0)};
        end
      end
      S_XBLK: begin
        entry_re = 1'b1;
      end
      S_XCMP: begin
        if (!(idx < fill_b && entry_q == addr)) begin
          if (idx_more) begin
            entry_re    = 1'b1;
            entry_raddr = blk_base + EAW'(idx + FW'(1));
          end else if (!link_b[LW-1]) begin
            meta_re    = 1'b1;
            meta_raddr = MAW'(link_b[BW-1:0]);
          end
        end
      end
      S_XSH: begin
        if (idx_more) begin
          entry_re    = 1'b1;
          entry_raddr = blk_base + EAW'(idx + FW'(1));
        end
      end
      S_XSW: begin
        entry_we    = 1'b1;
        entry_wdata = entry_q;
      end
      S_XFIN: begin
        meta_we = 1'b1;
        if (fill_b != FW'(1)) begin
          meta_wdata = {link_b, fill_b - FW'(1)};
        end else if (!prev[LW-1]) begin
          meta_waddr = MAW'(prev[BW-1:0]);
          meta_wdata = {link_b, prev_fill};
        end else begin
          meta_waddr = head_addr;
          meta_wdata = {link_b, FW'(0)};
        end
      end
      S_REC: begin
        meta_we    = 1'b1;
        meta_wdata = {spare_head, FW'(0)};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_q <= meta_mem[meta_raddr];
    end
    if (entry_we) begin
      entry_mem[entry_waddr] <= entry_wdata;
    end
    if (entry_re) begin
      entry_q <= entry_mem[entry_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      classes_in_use <= 9'd256;
      class_ne       <= '0;
      spare_head     <= LinkNull;
      fresh_count    <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        classes_in_use <= cfg_data;
      end
      if (state == S_FIN && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            act   <= action_t'(action);
            cls   <= size_class;
            addr  <= address;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          res  <= '0;
          st   <= ST_NONE;
          prev <= LinkNull;
          cur  <= {1'b0, cls};
          case (act)
            ACT_INSERT: begin
              if (!active) begin
                state <= S_FIN;
              end else if (class_ne[cls]) begin
                state <= S_IHEAD;
              end else begin
                state <= S_IALLOC;
              end
            end
            ACT_POP_LB: state <= S_SCAN;
            ACT_POP_EX: begin
              if (active && class_ne[cls]) begin
                state <= S_XHEAD;
              end else begin
                state <= S_FIN;
              end
            end
            default: state <= S_FIN;
          endcase
        end
        S_IHEAD: begin
          blk   <= mq_link[BW-1:0];
          state <= S_IBLK;
        end
        S_IBLK: begin
          if (mq_fill < FillMax) begin
            st    <= ST_DONE;
            state <= S_FIN;
          end else begin
            prev <= {1'b0, blk};
            if (mq_link[LW-1]) begin
              state <= S_IALLOC;
            end else begin
              blk <= mq_link[BW-1:0];
            end
          end
        end
        S_IALLOC: begin
          if (!spare_head[LW-1]) begin
            state <= S_ISPARE;
          end else if (fresh_count < CW'(NUM_BLOCKS)) begin
            blk         <= fresh_count[BW-1:0];
            fresh_count <= fresh_count + CW'(1);
            state       <= S_INEW;
          end else begin
            st    <= ST_FULL;
            state <= S_FIN;
          end
        end
        S_ISPARE: begin
          blk        <= spare_head[BW-1:0];
          spare_head <= mq_link;
          state      <= S_INEW;
        end
        S_INEW: begin
          state <= S_ILINK;
        end
        S_ILINK: begin
          if (prev[LW-1]) begin
            class_ne[cls] <= 1'b1;
          end
          st    <= ST_DONE;
          state <= S_FIN;
        end
        S_SCAN: begin
          if (cur >= lim) begin
            state <= S_FIN;
          end else if (class_ne[cur[7:0]]) begin
            state <= S_LHEAD;
          end else begin
            cur <= cur + 9'd1;
          end
        end
        S_LHEAD: begin
          blk   <= mq_link[BW-1:0];
          state <= S_LBLK;
        end
        S_LBLK: begin
          link_b <= mq_link;
          fill_b <= lb_fill;
          state  <= S_LENT;
        end
        S_LENT: begin
          res <= entry_q;
          st  <= ST_DONE;
          if (fill_b != FW'(1)) begin
            state <= S_FIN;
          end else begin
            class_ne[cur[7:0]] <= !link_b[LW-1];
            state              <= S_REC;
          end
        end
        S_XHEAD: begin
          blk   <= mq_link[BW-1:0];
          state <= S_XBLK;
        end
        S_XBLK: begin
          link_b <= mq_link;
          fill_b <= mq_fill;
          idx    <= '0;
          state  <= S_XCMP;
        end
        S_XCMP: begin
          if (idx < fill_b && entry_q == addr) begin
            state <= S_XSH;
          end else if (idx_more) begin
            idx <= idx + FW'(1);
          end else begin
            prev      <= {1'b0, blk};
            prev_fill <= fill_b;
            if (link_b[LW-1]) begin
              state <= S_FIN;
            end else begin
              blk   <= link_b[BW-1:0];
              state <= S_XBLK;
            end
          end
        end
        S_XSH: begin
          state <= idx_more ? S_XSW : S_XFIN;
        end
        S_XSW: begin
          idx   <= idx + FW'(1);
          state <= S_XSH;
        end
        S_XFIN: begin
          st <= ST_DONE;
          if (fill_b != FW'(1)) begin
            state <= S_FIN;
          end else begin
            if (prev[LW-1]) begin
              class_ne[cls] <= !link_b[LW-1];
            end
            state <= S_REC;
          end
        end
        S_REC: begin
          spare_head <= {1'b0, blk};
          state      <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      result_address <= (st == ST_DONE) ? res : '0;
      status         <= st;
    end
  end

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_count <= CW'(NUM_BLOCKS))
    else $error("fresh block count past store size");

  a_spare_used: assert property (@(posedge clk) disable iff (rst)
    !spare_head[LW-1] |-> fresh_count != '0)
    else $error("spare list holds a block never handed out");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_FIN))
    else $error("result raised outside finish");

  a_meta_rw: assert property (@(posedge clk) disable iff (rst)
    !(meta_we && meta_re && meta_waddr == meta_raddr))
    else $error("metadata read and write collide");

endmodule

`default_nettype wire

FILE: dv/size_binned_free_space_map_tb.sv
// ----------------------------------------------------------------------------
// size_binned_free_space_map_tb
// checks inserts, lower-bound pops and exact pops against a predictor of the
// class chains, with random sender bursts, receiver stalls and several class
// limits, including running the block store dry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module size_binned_free_space_map_tb;
  import sbfsm_pkg::*;

  localparam int Slots     = 8;
  localparam int Blocks    = 256;
  localparam int CycleCap  = 3000000;

  typedef struct {
    logic [31:0] addr;
    status_t     st;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        item_valid;
  logic        item_stall;
  logic [1:0]  action;
  logic [7:0]  size_class;
  logic [31:0] address;
  logic        result_valid;
  logic        result_stall;
  logic [31:0] result_address;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;

  size_binned_free_space_map u_top (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .action(action), .size_class(size_class), .address(address),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_address(result_address), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predicted map state, -1 is a null link
  int          head_of[NumClasses];
  int          blk_fill[Blocks];
  int          blk_link[Blocks];
  logic [31:0] blk_entry[Blocks*Slots];
  int          spare_top;
  int          fresh_next;
  int          class_lim;

  outcome_t    pending_q[$];
  logic [7:0]  pool_cls[$];
  logic [31:0] pool_addr[$];
  int          fail_count;
  int          items_sent;
  int          results_seen;
  int          exhausted_seen;
  int          cycles;
  int          burst_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleCap) begin
      $display("size_binned_free_space_map verification failed");
      $finish;
    end
  end

  // receiver stall pattern: calm, light or heavy, taken in turn
  always @(posedge clk) begin
    case ((cycles >> 6) % 3)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 99) < 25);
      default: result_stall <= ($urandom_range(0, 99) < 75);
    endcase
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen <= results_seen + 1;
      if (pending_q.size() == 0) begin
        $error("unexpected result address=%h status=%0d", result_address, status);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        if (result_address !== want.addr) begin
          $error("result_address expected %h actual %h", want.addr, result_address);
          fail_count++;
        end
        if (status !== want.st) begin
          $error("status expected %0d actual %0d", want.st, status);
          fail_count++;
        end
      end
    end
  end

  task automatic map_reset();
    foreach (head_of[i]) head_of[i] = -1;
    spare_top  = -1;
    fresh_next = 0;
    class_lim  = NumClasses;
  endtask

  task automatic map_apply(input action_t a, input logic [7:0] c, input logic [31:0] ad,
                           output logic [31:0] ra, output status_t st);
    int b;
    int last;
    int nb;
    int f;
    int cc;
    ra = '0;
    st = ST_NONE;
    case (a)
      ACT_INSERT: begin
        if (c >= class_lim) return;
        b = head_of[c];
        last = -1;
        while (b >= 0) begin
          f = blk_fill[b];
          if (f < Slots) begin
            blk_entry[b*Slots+f] = ad;
            blk_fill[b] = f + 1;
            st = ST_DONE;
            return;
          end
          last = b;
          b = blk_link[b];
        end
        if (spare_top >= 0) begin
          nb = spare_top;
          spare_top = blk_link[nb];
        end else if (fresh_next < Blocks) begin
          nb = fresh_next;
          fresh_next++;
        end else begin
          st = ST_FULL;
          return;
        end
        blk_fill[nb] = 1;
        blk_link[nb] = -1;
        blk_entry[nb*Slots] = ad;
        if (last >= 0) blk_link[last] = nb;
        else head_of[c] = nb;
        st = ST_DONE;
      end
      ACT_POP_LB: begin
        for (cc = c; cc < class_lim; cc++) begin
          b = head_of[cc];
          if (b < 0) continue;
          f = blk_fill[b];
          ra = blk_entry[b*Slots+f-1];
          blk_fill[b] = f - 1;
          if (f == 1) begin
            head_of[cc] = blk_link[b];
            blk_link[b] = spare_top;
            spare_top = b;
          end
          st = ST_DONE;
          return;
        end
      end
      ACT_POP_EX: begin
        if (c >= class_lim) return;
        b = head_of[c];
        last = -1;
        while (b >= 0) begin
          f = blk_fill[b];
          for (int i = 0; i < f; i++) begin
            if (blk_entry[b*Slots+i] != ad) continue;
            for (int j = i; j + 1 < f; j++) blk_entry[b*Slots+j] = blk_entry[b*Slots+j+1];
            blk_fill[b] = f - 1;
            if (f == 1) begin
              if (last >= 0) blk_link[last] = blk_link[b];
              else head_of[c] = blk_link[b];
              blk_link[b] = spare_top;
              spare_top = b;
            end
            st = ST_DONE;
            return;
          end
          last = b;
          b = blk_link[b];
        end
      end
      default: ;
    endcase
  endtask

  // sends one item in bursts with random gaps, then books its outcome
  task automatic push_item(input action_t a, input logic [7:0] c, input logic [31:0] ad);
    outcome_t o;
    if (burst_left == 0) begin
      if (item_valid) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    item_valid <= 1'b1;
    action     <= a;
    size_class <= c;
    address    <= ad;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    map_apply(a, c, ad, o.addr, o.st);
    if (o.st == ST_FULL) exhausted_seen++;
    if (a == ACT_INSERT && o.st == ST_DONE) begin
      pool_cls.push_back(c);
      pool_addr.push_back(ad);
      if (pool_cls.size() > 64) begin
        void'(pool_cls.pop_front());
        void'(pool_addr.pop_front());
      end
    end
    pending_q.push_back(o);
    items_sent++;
  endtask

  task automatic drain();
    if (item_valid) item_valid <= 1'b0;
    burst_left = 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_class_limit(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v[8:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    class_lim = (v > NumClasses) ? NumClasses : v;
  endtask

  task automatic test_directed();
    push_item(ACT_POP_LB, 8'd0, 32'h0);
    push_item(ACT_POP_EX, 8'd9, 32'h1234);
    push_item(ACT_INSERT, 8'd0, 32'h0);
    push_item(ACT_INSERT, 8'd255, 32'hffff_ffff);
    push_item(ACT_POP_LB, 8'd0, 32'hffff_ffff);
    push_item(ACT_POP_LB, 8'd1, 32'h0);
    push_item(ACT_POP_LB, 8'd255, 32'h0);
    push_item(ACT_INSERT, 8'd5, 32'haaaa_0001);
    push_item(ACT_INSERT, 8'd5, 32'h5555_0002);
    push_item(ACT_INSERT, 8'd5, 32'haaaa_0003);
    push_item(ACT_POP_EX, 8'd5, 32'hdead_beef);
    push_item(ACT_POP_EX, 8'd5, 32'h5555_0002);
    push_item(ACT_POP_EX, 8'd5, 32'haaaa_0001);
    push_item(ACT_POP_LB, 8'd3, 32'h0);
    push_item(ACT_NONE, 8'd7, 32'h7777_7777);
    set_class_limit(1);
    push_item(ACT_INSERT, 8'd3, 32'h3333);
    push_item(ACT_POP_EX, 8'd3, 32'h3333);
    push_item(ACT_POP_LB, 8'd3, 32'h0);
    push_item(ACT_INSERT, 8'd0, 32'h0bad_cafe);
    push_item(ACT_POP_LB, 8'd0, 32'h0);
    set_class_limit(256);
  endtask

  // one full block in class 0 plus one block per other class uses every block
  task automatic test_exhaust();
    for (int i = 0; i < Slots; i++) push_item(ACT_INSERT, 8'd0, $urandom);
    for (int c = 1; c < NumClasses; c++) push_item(ACT_INSERT, c[7:0], $urandom);
    push_item(ACT_INSERT, 8'd0, 32'h1111_2222);
    push_item(ACT_INSERT, 8'd0, 32'h3333_4444);
    for (int i = 0; i < Slots + NumClasses - 1; i++) push_item(ACT_POP_LB, 8'd0, $urandom);
    push_item(ACT_POP_LB, 8'd0, 32'h0);
  endtask

  task automatic test_random(input int count, input int span);
    int r;
    int k;
    logic [7:0] c;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, span));
      if (n == count / 2) drain();
      if (r < 45) begin
        push_item(ACT_INSERT, c, ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15))
                                                               : $urandom);
      end else if (r < 75) begin
        if (pool_cls.size() != 0 && $urandom_range(0, 4) != 0) begin
          k = $urandom_range(0, pool_cls.size() - 1);
          push_item(ACT_POP_EX, pool_cls[k], pool_addr[k]);
        end else begin
          push_item(ACT_POP_EX, c, $urandom);
        end
      end else if (r < 95) begin
        push_item(ACT_POP_LB, c, $urandom);
      end else begin
        push_item(ACT_NONE, 8'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    item_valid   = 1'b0;
    action       = '0;
    size_class   = '0;
    address      = '0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    cycles       = 0;
    fail_count   = 0;
    items_sent   = 0;
    results_seen = 0;
    exhausted_seen = 0;
    burst_left   = 0;
    map_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_exhaust();
    set_class_limit(256);
    test_random(350, 7);
    set_class_limit(255);
    test_random(280, 20);
    set_class_limit(1);
    test_random(140, 3);
    set_class_limit($urandom_range(2, 32));
    test_random(350, 40);
    set_class_limit(256);
    test_random(130, 255);

    drain();
    $display("sent %0d items, checked %0d results, %0d inserts dropped on a full store",
             items_sent, results_seen, exhausted_seen);
    $display("class limits 1, 255, 256 and one random, with sender gaps and receiver stalls");
    if (fail_count == 0) begin
      $display("size_binned_free_space_map verification clean");
    end else begin
      $display("size_binned_free_space_map verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
hw/rtl/sbfsm_pkg.sv
hw/rtl/size_binned_free_space_map.sv
dv/size_binned_free_space_map_tb.sv
